FILE: src/ngss_pkg.sv
// shared constants, types and helper functions for the nearest grid site snap block
`timescale 1ns / 1ps
package ngss_pkg;

  localparam int unsigned MaxEntriesDef = 8;
  localparam int unsigned CoordBitsDef  = 16;
  localparam int unsigned CfgW          = 4;
  localparam int unsigned SlotW         = 3;
  localparam int unsigned PitchW        = 12;
  localparam int unsigned CountW        = 11;
  localparam int unsigned SiteW         = 10;
  localparam int unsigned NumW          = 22;
  localparam int unsigned QuotW         = 10;
  localparam int unsigned MaxSite       = 1023;

  typedef enum logic {
    FuncLoad  = 1'b0,
    FuncQuery = 1'b1
  } func_e;

  // one axis of the snap divider
  typedef struct packed {
    logic              over;
    logic              under;
    logic [SiteW-1:0]  cm;
    logic [PitchW-1:0] p;
    logic [PitchW-1:0] rem;
    logic [QuotW-1:0]  q;
    logic [QuotW-1:0]  lo;
  } lane_t;

  function automatic int unsigned hi_bits(int unsigned c);
    return c + 23;
  endfunction

  function automatic int unsigned gap_bits(int unsigned c);
    return 2 * c + 1;
  endfunction

  function automatic int unsigned grid_bits(int unsigned c);
    return 2 * c + 2 * hi_bits(c) + 2 * PitchW + 2 * SiteW;
  endfunction

  function automatic int unsigned item_bits(int unsigned c);
    return 1 + SlotW + 2 * grid_bits(c) + 2 * c + SlotW + gap_bits(c);
  endfunction

  // count minus one, zero read as one, saturated at the largest grid
  function automatic logic [SiteW-1:0] count_m1(logic [CountW-1:0] n);
    logic [SiteW-1:0] r;
    if (n == '0) begin
      r = '0;
    end else if (n > CountW'(MaxSite + 1)) begin
      r = SiteW'(MaxSite);
    end else begin
      r = SiteW'(n - CountW'(1));
    end
    return r;
  endfunction

  // one restoring division step, one quotient bit
  function automatic lane_t div_step(lane_t l);
    lane_t             r;
    logic [PitchW:0]   t;
    logic              ge;
    r  = l;
    t  = {l.rem, l.lo[QuotW-1]};
    ge = (t >= {1'b0, l.p});
    r.rem = ge ? PitchW'(t - {1'b0, l.p}) : t[PitchW-1:0];
    r.q   = {l.q[QuotW-2:0], ge};
    r.lo  = {l.lo[QuotW-2:0], 1'b0};
    return r;
  endfunction

  function automatic logic [SiteW-1:0] snap_site(lane_t l);
    logic [SiteW-1:0] r;
    if (l.over) begin
      r = l.cm;
    end else if (l.under) begin
      r = '0;
    end else begin
      r = l.q;
    end
    return r;
  endfunction

endpackage

FILE: src/ngss_entry.sv
// one table entry with its two search stages: squared gaps, then best-so-far update
`timescale 1ns / 1ps
module ngss_entry #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned COORD_BITS = ngss_pkg::CoordBitsDef,
  localparam int unsigned ItemW     = ngss_pkg::item_bits(COORD_BITS)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic [ngss_pkg::CfgW-1:0] active_i,
  input  logic                      valid_i,
  input  logic [ItemW-1:0]          item_i,
  output logic                      valid_o,
  output logic [ItemW-1:0]          item_o
);
  import ngss_pkg::*;

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned HW = hi_bits(COORD_BITS);
  localparam int unsigned GW = gap_bits(COORD_BITS);

  typedef struct packed {
    logic [C-1:0]      ox;
    logic [C-1:0]      oy;
    logic [HW-1:0]     hx;
    logic [HW-1:0]     hy;
    logic [PitchW-1:0] px;
    logic [PitchW-1:0] py;
    logic [SiteW-1:0]  cx;
    logic [SiteW-1:0]  cy;
  } grid_t;

  typedef struct packed {
    logic             query;
    logic [SlotW-1:0] slot;
    grid_t            ld;
    logic [C-1:0]     qx;
    logic [C-1:0]     qy;
    logic [SlotW-1:0] best;
    logic [GW-1:0]    gap;
    grid_t            bg;
  } item_t;

  item_t           it_in;
  grid_t           ent_q;
  logic [C-1:0]    dx, dy;
  logic [2*C-1:0]  dx2_d, dy2_d;
  logic            use_d;

  logic            va_q;
  item_t           a_it_q;
  grid_t           a_ent_q;
  logic [2*C-1:0]  a_dx2_q, a_dy2_q;
  logic            a_use_q;

  logic [GW-1:0]   g;
  logic            take;
  item_t           b_it_d;
  logic            vb_q;
  item_t           b_it_q;

  assign it_in = item_i;

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i && !it_in.query && (32'(it_in.slot) == 32'(IDX))) begin
      ent_q <= it_in.ld;
    end
  end

  always_comb begin
    if (it_in.qx < ent_q.ox) begin
      dx = ent_q.ox - it_in.qx;
    end else if (HW'(it_in.qx) > ent_q.hx) begin
      dx = C'(HW'(it_in.qx) - ent_q.hx);
    end else begin
      dx = '0;
    end
    if (it_in.qy < ent_q.oy) begin
      dy = ent_q.oy - it_in.qy;
    end else if (HW'(it_in.qy) > ent_q.hy) begin
      dy = C'(HW'(it_in.qy) - ent_q.hy);
    end else begin
      dy = '0;
    end
    dx2_d = {{C{1'b0}}, dx} * {{C{1'b0}}, dx};
    dy2_d = {{C{1'b0}}, dy} * {{C{1'b0}}, dy};
    use_d = (IDX == 0) || (32'(active_i) > 32'(IDX));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (adv_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_it_q  <= it_in;
      a_ent_q <= ent_q;
      a_dx2_q <= dx2_d;
      a_dy2_q <= dy2_d;
      a_use_q <= use_d;
      b_it_q  <= b_it_d;
    end
  end

  always_comb begin
    g      = GW'(a_dx2_q) + GW'(a_dy2_q);
    take   = a_it_q.query && a_use_q && ((IDX == 0) || (g < a_it_q.gap));
    b_it_d = a_it_q;
    if (take) begin
      b_it_d.best = SlotW'(IDX);
      b_it_d.gap  = g;
      b_it_d.bg   = a_ent_q;
    end
  end

  assign valid_o = vb_q;
  assign item_o  = b_it_q;

  // a later entry never raises the best gap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (IDX != 0) && adv_i && va_q && a_it_q.query |=> (b_it_q.gap <= $past(a_it_q.gap)))
    else $error("best gap grew at a later entry");

endmodule

FILE: src/ngss_snap.sv
// snap stage: clamp flags, rounded offsets and a pipelined divider for both axes
`timescale 1ns / 1ps
module ngss_snap #(
  parameter int unsigned COORD_BITS = ngss_pkg::CoordBitsDef,
  localparam int unsigned ItemW     = ngss_pkg::item_bits(COORD_BITS),
  localparam int unsigned ResW      = 2 * ngss_pkg::SiteW + ngss_pkg::SlotW
                                      + ngss_pkg::gap_bits(COORD_BITS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             valid_i,
  input  logic [ItemW-1:0] item_i,
  output logic             valid_o,
  output logic [ResW-1:0]  res_o
);
  import ngss_pkg::*;

  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned HW    = hi_bits(COORD_BITS);
  localparam int unsigned GW    = gap_bits(COORD_BITS);
  localparam int unsigned Last  = QuotW;

  typedef struct packed {
    logic [C-1:0]      ox;
    logic [C-1:0]      oy;
    logic [HW-1:0]     hx;
    logic [HW-1:0]     hy;
    logic [PitchW-1:0] px;
    logic [PitchW-1:0] py;
    logic [SiteW-1:0]  cx;
    logic [SiteW-1:0]  cy;
  } grid_t;

  typedef struct packed {
    logic             query;
    logic [SlotW-1:0] slot;
    grid_t            ld;
    logic [C-1:0]     qx;
    logic [C-1:0]     qy;
    logic [SlotW-1:0] best;
    logic [GW-1:0]    gap;
    grid_t            bg;
  } item_t;

  typedef struct packed {
    logic [SlotW-1:0] idx;
    logic [GW-1:0]    gap;
  } tag_t;

  item_t            it;
  lane_t            lx_d, ly_d;
  logic [HW-1:0]    numx, numy;
  logic [Last:0]    v_q;
  lane_t            lx_q [Last+1];
  lane_t            ly_q [Last+1];
  tag_t             tg_q [Last+1];
  logic [SiteW-1:0] row, col;

  assign it = item_i;

  always_comb begin
    numx = HW'(it.qx) - HW'(it.bg.ox) + HW'(it.bg.px >> 1);
    numy = HW'(it.qy) - HW'(it.bg.oy) + HW'(it.bg.py >> 1);

    lx_d.over  = HW'(it.qx) > it.bg.hx;
    lx_d.under = (it.qx < it.bg.ox) || (it.bg.px == '0);
    lx_d.cm    = it.bg.cx;
    lx_d.p     = it.bg.px;
    lx_d.rem   = numx[NumW-1:QuotW];
    lx_d.q     = '0;
    lx_d.lo    = numx[QuotW-1:0];

    ly_d.over  = HW'(it.qy) > it.bg.hy;
    ly_d.under = (it.qy < it.bg.oy) || (it.bg.py == '0);
    ly_d.cm    = it.bg.cy;
    ly_d.p     = it.bg.py;
    ly_d.rem   = numy[NumW-1:QuotW];
    ly_d.q     = '0;
    ly_d.lo    = numy[QuotW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[Last-1:0], valid_i && it.query};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      lx_q[0]     <= lx_d;
      ly_q[0]     <= ly_d;
      tg_q[0].idx <= it.best;
      tg_q[0].gap <= it.gap;
      for (int k = 1; k <= Last; k++) begin
        lx_q[k] <= div_step(lx_q[k-1]);
        ly_q[k] <= div_step(ly_q[k-1]);
        tg_q[k] <= tg_q[k-1];
      end
    end
  end

  assign row     = snap_site(ly_q[Last]);
  assign col     = snap_site(lx_q[Last]);
  assign valid_o = v_q[Last];
  assign res_o   = {tg_q[Last].gap, col, row, tg_q[Last].idx};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[Last] |-> (row <= ly_q[Last].cm))
    else $error("row beyond grid");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[Last] |-> (col <= lx_q[Last].cm))
    else $error("column beyond grid");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> (v_q == $past(v_q)))
    else $error("divider moved while stalled");

endmodule

FILE: src/nearest_grid_site_snap.sv
// top level: input stage, entry search chain, snap divider and output register
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid_i/tready_o     tuser func, tdata load or query fields
// m_axis    out  m_axis_tvalid_o/tready_i     tdata nearest_entry, site_row, site_col, gap
// cfg       in   cfg_we_i                     cfg_wdata_i active_entries
//
// 2*MAX_ENTRIES + 13 stages from accept to result valid
// one item enters per cycle unless stalled; the entry chain has two stages per table entry
// loads travel the chain and write their entry in passing, so queries see earlier loads
// a stalled result freezes the whole pipeline; nothing is dropped or repeated
// reset clears valid bits and sets active_entries to 1; table contents start undefined
`timescale 1ns / 1ps
module nearest_grid_site_snap #(
  parameter int unsigned MAX_ENTRIES = ngss_pkg::MaxEntriesDef,
  parameter int unsigned COORD_BITS  = ngss_pkg::CoordBitsDef,
  localparam int unsigned InBits  = 49 + 4 * COORD_BITS,
  localparam int unsigned InW     = ((InBits + 7) / 8) * 8,
  localparam int unsigned OutBits = 2 * ngss_pkg::SiteW + ngss_pkg::SlotW
                                    + ngss_pkg::gap_bits(COORD_BITS),
  localparam int unsigned OutW    = ((OutBits + 7) / 8) * 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // entry_index, origin_x, origin_y, pitch_x, pitch_y, row_count, col_count, query_x, query_y
  input  logic [InW-1:0]            s_axis_tdata_i,
  // func
  input  logic                      s_axis_tuser_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // nearest_entry, site_row, site_col, gap_squared
  output logic [OutW-1:0]           m_axis_tdata_o,
  input  logic                      cfg_we_i,
  input  logic [ngss_pkg::CfgW-1:0] cfg_wdata_i
);
  import ngss_pkg::*;

  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned HW    = hi_bits(COORD_BITS);
  localparam int unsigned GW    = gap_bits(COORD_BITS);
  localparam int unsigned ItemW = item_bits(COORD_BITS);

  typedef struct packed {
    logic [C-1:0]      ox;
    logic [C-1:0]      oy;
    logic [HW-1:0]     hx;
    logic [HW-1:0]     hy;
    logic [PitchW-1:0] px;
    logic [PitchW-1:0] py;
    logic [SiteW-1:0]  cx;
    logic [SiteW-1:0]  cy;
  } grid_t;

  typedef struct packed {
    logic             query;
    logic [SlotW-1:0] slot;
    grid_t            ld;
    logic [C-1:0]     qx;
    logic [C-1:0]     qy;
    logic [SlotW-1:0] best;
    logic [GW-1:0]    gap;
    grid_t            bg;
  } item_t;

  logic              adv;
  logic [CfgW-1:0]   active_q;
  item_t             f_it_d;
  logic              f_v_q;
  item_t             f_it_q;
  logic              chain_v  [MAX_ENTRIES+1];
  logic [ItemW-1:0]  chain_it [MAX_ENTRIES+1];
  logic              snap_v;
  logic [OutBits-1:0] snap_res;
  logic              out_v_q;
  logic [OutBits-1:0] out_q;

  assign adv             = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= CfgW'(1);
    end else if (cfg_we_i) begin
      active_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    f_it_d       = '0;
    f_it_d.query = (func_e'(s_axis_tuser_i) == FuncQuery);
    f_it_d.slot  = s_axis_tdata_i[SlotW-1:0];
    f_it_d.ld.ox = s_axis_tdata_i[3 +: C];
    f_it_d.ld.oy = s_axis_tdata_i[3 + C +: C];
    f_it_d.ld.px = s_axis_tdata_i[3 + 2 * C +: PitchW];
    f_it_d.ld.py = s_axis_tdata_i[15 + 2 * C +: PitchW];
    f_it_d.ld.cy = count_m1(s_axis_tdata_i[27 + 2 * C +: CountW]);
    f_it_d.ld.cx = count_m1(s_axis_tdata_i[38 + 2 * C +: CountW]);
    f_it_d.qx    = s_axis_tdata_i[49 + 2 * C +: C];
    f_it_d.qy    = s_axis_tdata_i[49 + 3 * C +: C];
    f_it_d.ld.hx = HW'(f_it_d.ld.ox) + HW'(NumW'(f_it_d.ld.cx) * NumW'(f_it_d.ld.px));
    f_it_d.ld.hy = HW'(f_it_d.ld.oy) + HW'(NumW'(f_it_d.ld.cy) * NumW'(f_it_d.ld.py));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      f_v_q   <= s_axis_tvalid_i;
      out_v_q <= snap_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_it_q <= f_it_d;
      out_q  <= snap_res;
    end
  end

  assign chain_v[0]  = f_v_q;
  assign chain_it[0] = f_it_q;

  for (genvar e = 0; e < MAX_ENTRIES; e++) begin : g_entry
    ngss_entry #(
      .IDX        (e),
      .COORD_BITS (COORD_BITS)
    ) u_entry (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .adv_i    (adv),
      .active_i (active_q),
      .valid_i  (chain_v[e]),
      .item_i   (chain_it[e]),
      .valid_o  (chain_v[e+1]),
      .item_o   (chain_it[e+1])
    );
  end

  ngss_snap #(
    .COORD_BITS (COORD_BITS)
  ) u_snap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (chain_v[MAX_ENTRIES]),
    .item_i  (chain_it[MAX_ENTRIES]),
    .valid_o (snap_v),
    .res_o   (snap_res)
  );

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = OutW'(out_q);

endmodule
